/* design/esa_pkg.sv */
// Shared types, sizes and codes for the entity slot allocator.
package esa_pkg;

	localparam int NUM_SLOTS      = 1024;
	localparam int NUM_ARCHETYPES = 32;
	localparam int MAX_ROWS       = 4096;
	localparam int MAP_WORD_BITS  = 32;
	localparam int MAP_WORDS      = (NUM_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

	localparam int SLOT_W  = $clog2(NUM_SLOTS);
	localparam int WORD_W  = $clog2(MAP_WORDS);
	localparam int BIT_W   = $clog2(MAP_WORD_BITS);
	localparam int ARCH_W  = $clog2(NUM_ARCHETYPES);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int CNT_W   = ROW_W + 1;
	localparam int FREE_W  = SLOT_W + 1;
	localparam int GEN_W   = 32;
	localparam int LOC_W   = ARCH_W + ROW_W;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 96;

	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_DESTROY = 3'd1;
	localparam logic [2:0] CMD_TEMP    = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_SET     = 3'd4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_SLOT = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	typedef enum logic [2:0] {
		OP_CREATE, OP_DESTROY, OP_TEMP, OP_CLEAR, OP_SET, OP_NONE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ARCH_W-1:0] arch;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  row_count;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_ctl_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_FETCH, S_SCAN, S_GEN, S_DROWS
	} state_t;

	function automatic logic [BIT_W-1:0] lowest_bit(input logic [MAP_WORD_BITS-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
			if (w[i])
				r = BIT_W'(i);
		return r;
	endfunction

endpackage

/* design/entity_slot_allocator_core.sv */
// Top level of the entity slot allocator.
// Input channel s_*: one command per transaction (create, destroy, reserve
// temporary row, clear rows, set rows). Output channel m_*: exactly one
// result transaction per command, in command order.
// After reset a clearing pass zeroes the generation memory, marks every
// bitmap word free and zeroes all row counts; s_tready is low for that time.
// A two-entry command queue sits in front of the execution sequencer, so
// commands are taken while a result waits on the output register.
// Temporary, clear, set, unknown codes, rejected creates and destroys of free
// slots finish in the fetch step; destroy of a live slot then updates the row
// count of its archetype; create then scans the bitmap memory one word per
// cycle for the first word holding a free slot (its index is up to 31) and
// then writes the generation and location. Commands execute one at a time;
// a new one starts only once the output register is empty.
// When the receiver holds m_tready low the result stays on m_tdata, the
// queue fills and then s_tready drops.
module entity_slot_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // cmd[2:0], archetype[7:3], slot[17:8], row_count[30:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // status[1:0], slot_id[11:2], generation[43:12],
	                              // row[55:44], move_needed[56], move_from_row[68:57],
	                              // rows_now[81:69], free_slots[92:82]
);
	import esa_pkg::*;

	back_ctl_t ctl;
	item_t     item;
	logic      item_valid;

	esa_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .ctl, .item_valid, .item);

	esa_back u_back (
		.clk, .arst_n, .item_valid, .item, .ctl, .m_tvalid, .m_tready, .m_tdata);
endmodule

/* design/esa_ram.sv */
// Generic single write, single read RAM with registered read data.
module esa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* design/esa_front.sv */
// Front end: accepts command transactions, decodes them, two-entry queue.
module esa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // cmd[2:0], archetype, slot, row_count, zero pad
	input  esa_pkg::back_ctl_t    ctl,
	output logic                  item_valid,
	output esa_pkg::item_t        item
);
	import esa_pkg::*;

	item_t      buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	item_t      dec;
	logic       push;

	always_comb begin
		dec.arch      = s_tdata[7:3];
		dec.slot      = s_tdata[17:8];
		dec.row_count = s_tdata[30:18];
		case (s_tdata[2:0])
			CMD_CREATE:  dec.op = OP_CREATE;
			CMD_DESTROY: dec.op = OP_DESTROY;
			CMD_TEMP:    dec.op = OP_TEMP;
			CMD_CLEAR:   dec.op = OP_CLEAR;
			CMD_SET:     dec.op = OP_SET;
			default:     dec.op = OP_NONE;
		endcase
	end

	assign s_tready   = (cnt_q != 2'd2) && !ctl.clearing;
	assign push       = s_tvalid && s_tready;
	assign item_valid = cnt_q != 2'd0;
	assign item       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (ctl.pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
		end
	end
endmodule

/* design/esa_back.sv */
// Back end: executes commands against slot, bitmap and row-count memories.
module esa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  esa_pkg::item_t      item,
	output esa_pkg::back_ctl_t  ctl,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [95:0]         m_tdata
);
	import esa_pkg::*;

	state_t state_q, state_d;
	item_t  cur_q;
	logic [SLOT_W-1:0] clr_q;
	logic [WORD_W-1:0] wcnt_q;
	logic [CNT_W-1:0]  rows_q;
	logic [FREE_W-1:0] free_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROW_W-1:0]  drow_q;
	logic [ARCH_W-1:0] darch_q;

	// result register
	logic [1:0]        o_status_q;
	logic [SLOT_W-1:0] o_slot_q;
	logic [GEN_W-1:0]  o_gen_q;
	logic [ROW_W-1:0]  o_row_q;
	logic              o_mv_q;
	logic [ROW_W-1:0]  o_from_q;
	logic [CNT_W-1:0]  o_rows_q;
	logic              o_valid_q;

	// memory ports
	logic map_we, gen_we, loc_we, rows_we;
	logic [WORD_W-1:0] map_wa, map_ra;
	logic [SLOT_W-1:0] gen_wa, gen_ra, loc_wa, loc_ra;
	logic [ARCH_W-1:0] rows_wa, rows_ra;
	logic [MAP_WORD_BITS-1:0] map_wd, map_rd;
	logic [GEN_W-1:0] gen_wd, gen_rd;
	logic [LOC_W-1:0] loc_wd, loc_rd;
	logic [CNT_W-1:0] rows_wd, rows_rd;

	esa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
		.clk, .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_rd));
	esa_ram #(.WIDTH(GEN_W), .DEPTH(NUM_SLOTS)) u_gen (
		.clk, .we(gen_we), .waddr(gen_wa), .wdata(gen_wd), .raddr(gen_ra), .rdata(gen_rd));
	esa_ram #(.WIDTH(LOC_W), .DEPTH(NUM_SLOTS)) u_loc (
		.clk, .we(loc_we), .waddr(loc_wa), .wdata(loc_wd), .raddr(loc_ra), .rdata(loc_rd));
	esa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_ARCHETYPES)) u_rows (
		.clk, .we(rows_we), .waddr(rows_wa), .wdata(rows_wd), .raddr(rows_ra), .rdata(rows_rd));

	logic [BIT_W-1:0]  fbit;
	logic [BIT_W-1:0]  dbit;
	logic              full;
	logic [CNT_W-1:0]  last;
	logic [CNT_W-1:0]  sat;

	assign fbit = lowest_bit(map_rd);
	assign dbit = cur_q.slot[BIT_W-1:0];
	assign full = rows_rd >= CNT_W'(MAX_ROWS);
	assign last = rows_rd - CNT_W'(1);
	assign sat  = (cur_q.row_count > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cur_q.row_count;

	assign ctl.clearing = state_q == S_CLEAR;
	assign ctl.pop      = state_q == S_IDLE && item_valid && !o_valid_q;

	always_comb begin
		state_d = state_q;
		map_we = 1'b0; gen_we = 1'b0; loc_we = 1'b0; rows_we = 1'b0;
		map_wa = cur_q.slot[SLOT_W-1:BIT_W];
		map_wd = map_rd | (MAP_WORD_BITS'(1) << dbit);
		map_ra = item.slot[SLOT_W-1:BIT_W];
		gen_wa = cur_q.slot;
		gen_wd = gen_rd + GEN_W'(1);
		gen_ra = item.slot;
		loc_wa = slot_q;
		loc_wd = {cur_q.arch, rows_q[ROW_W-1:0]};
		loc_ra = item.slot;
		rows_wa = cur_q.arch;
		rows_wd = rows_q + CNT_W'(1);
		rows_ra = item.arch;
		case (state_q)
			S_CLEAR: begin
				gen_we = 1'b1; gen_wa = clr_q; gen_wd = '0;
				map_we = clr_q < SLOT_W'(MAP_WORDS); map_wa = clr_q[WORD_W-1:0]; map_wd = '1;
				rows_we = clr_q < SLOT_W'(NUM_ARCHETYPES);
				rows_wa = clr_q[ARCH_W-1:0]; rows_wd = '0;
				if (clr_q == SLOT_W'(NUM_SLOTS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (ctl.pop)
					state_d = S_FETCH;
			end
			S_FETCH: begin
				state_d = S_IDLE;
				case (cur_q.op)
					OP_CREATE: begin
						if (free_q != '0 && !full) begin
							map_ra = '0;
							state_d = S_SCAN;
						end
					end
					OP_DESTROY: begin
						if (!map_rd[dbit]) begin
							map_we = 1'b1;
							gen_we = 1'b1;
							rows_ra = loc_rd[LOC_W-1:ROW_W];
							state_d = S_DROWS;
						end
					end
					OP_TEMP: begin
						rows_we = !full; rows_wd = rows_rd + CNT_W'(1);
					end
					OP_CLEAR: begin
						rows_we = 1'b1; rows_wd = '0;
					end
					OP_SET: begin
						rows_we = 1'b1; rows_wd = sat;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				map_ra = wcnt_q + WORD_W'(1);
				if (map_rd != '0) begin
					map_we = 1'b1; map_wa = wcnt_q;
					map_wd = map_rd & ~(MAP_WORD_BITS'(1) << fbit);
					gen_ra = {wcnt_q, fbit};
					state_d = S_GEN;
				end
			end
			S_GEN: begin
				gen_we = 1'b1; gen_wa = slot_q;
				loc_we = 1'b1;
				rows_we = 1'b1;
				state_d = S_IDLE;
			end
			S_DROWS: begin
				rows_we = rows_rd != '0; rows_wa = darch_q; rows_wd = last;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			free_q    <= FREE_W'(NUM_SLOTS);
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + SLOT_W'(1);
			if (m_tready)
				o_valid_q <= 1'b0;
			case (state_q)
				S_FETCH: begin
					if (cur_q.op == OP_DESTROY && !map_rd[dbit])
						free_q <= free_q + FREE_W'(1);
					else if (!(cur_q.op == OP_CREATE && free_q != '0 && !full))
						o_valid_q <= 1'b1;
				end
				S_GEN: begin
					free_q    <= free_q - FREE_W'(1);
					o_valid_q <= 1'b1;
				end
				S_DROWS: o_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop)
			cur_q <= item;
		case (state_q)
			S_FETCH: begin
				rows_q     <= rows_rd;
				wcnt_q     <= '0;
				o_status_q <= STAT_OK;
				o_slot_q   <= '0;
				o_gen_q    <= '0;
				o_row_q    <= '0;
				o_mv_q     <= 1'b0;
				o_from_q   <= '0;
				o_rows_q   <= rows_rd;
				case (cur_q.op)
					OP_CREATE: begin
						if (free_q == '0)
							o_status_q <= STAT_NO_SLOT;
						else if (rows_rd >= CNT_W'(MAX_ROWS))
							o_status_q <= STAT_FULL;
					end
					OP_DESTROY: begin
						o_slot_q <= cur_q.slot;
						o_rows_q <= '0;
						if (map_rd[dbit]) begin
							o_gen_q <= gen_rd;
						end else begin
							o_gen_q <= gen_rd + GEN_W'(1);
							o_row_q <= loc_rd[ROW_W-1:0];
							drow_q  <= loc_rd[ROW_W-1:0];
							darch_q <= loc_rd[LOC_W-1:ROW_W];
						end
					end
					OP_TEMP: begin
						if (rows_rd >= CNT_W'(MAX_ROWS)) begin
							o_status_q <= STAT_FULL;
						end else begin
							o_row_q  <= rows_rd[ROW_W-1:0];
							o_rows_q <= rows_rd + CNT_W'(1);
						end
					end
					OP_CLEAR: o_rows_q <= '0;
					OP_SET: o_rows_q <= (cur_q.row_count > CNT_W'(MAX_ROWS)) ?
						CNT_W'(MAX_ROWS) : cur_q.row_count;
					default: ;
				endcase
			end
			S_SCAN: begin
				wcnt_q <= wcnt_q + WORD_W'(1);
				slot_q <= {wcnt_q, fbit};
			end
			S_GEN: begin
				o_slot_q <= slot_q;
				o_gen_q  <= gen_rd + GEN_W'(1);
				o_row_q  <= rows_q[ROW_W-1:0];
				o_rows_q <= rows_q + CNT_W'(1);
			end
			S_DROWS: begin
				if (rows_rd != '0) begin
					o_rows_q <= last;
					if ({1'b0, drow_q} != last) begin
						o_mv_q   <= 1'b1;
						o_from_q <= last[ROW_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {3'b000, free_q, o_rows_q, o_from_q, o_mv_q, o_row_q, o_gen_q,
		o_slot_q, o_status_q};
endmodule

/* design/esa_checker.sv */
// Port-level checks for the entity slot allocator, bound to the top level.
module esa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);
	import esa_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] <= STAT_FULL)
		else $error("bad status code");

	a_free_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[92:82] <= FREE_W'(NUM_SLOTS))
		else $error("free count too large");

	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STAT_NO_SLOT |-> m_tdata[92:82] == '0)
		else $error("no-slot status with free slots");
endmodule

bind entity_slot_allocator_core esa_checker u_chk (.*);
